[hdl/stq_pkg.sv]
// Shared types, codes and sizes for the sorted timer queue.
// Used by stq_cmp and sorted_timer_queue_core; depends on nothing else.
package stq_pkg;

  localparam int TIMER_SLOTS  = 16;
  localparam int TIME_BITS    = 48;
  localparam int ID_BITS      = 16;
  localparam int OWNER_BITS   = 8;
  localparam int RESULT_LIMIT = 16;

  localparam int IDX_W  = $clog2(TIMER_SLOTS);
  localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
  localparam int NPOP_W = $clog2(RESULT_LIMIT + 1);

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_CHECK  = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NULL_OWNER = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] timer_id;
    logic [7:0]  owner_block;
    logic [47:0] delay;
    logic [47:0] now;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        expired_valid;
    logic [15:0] timer_id_res;
    logic [7:0]  owner_block_res;
    logic [47:0] expiry_time;
    logic        last;
  } res_word_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  expiry;
    logic [ID_BITS-1:0]    id;
    logic [OWNER_BITS-1:0] owner;
  } entry_t;

  typedef struct packed {
    logic id_match;
    logic earlier;
  } cmp_res_t;

endpackage

[hdl/stq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds one bank of timer entries in this design.
module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/stq_cmp.sv]
// Shared compare unit: matches an entry's id and orders its expiry against a key.
// Depends on stq_pkg for the entry and result types.
module stq_cmp (
  input  stq_pkg::entry_t                  entry,
  input  logic [stq_pkg::TIME_BITS-1:0]    key_time,
  input  logic [stq_pkg::ID_BITS-1:0]      key_id,
  output stq_pkg::cmp_res_t                result
);
  import stq_pkg::*;

  // The key is the new expiry for an add and the current time for a check.
  assign result.id_match = (entry.id == key_id);
  assign result.earlier  = (entry.expiry < key_time);

endmodule

[hdl/sorted_timer_queue_core.sv]
// Top level of the sorted timer queue: sequencer, two entry banks and compare unit.
// Depends on stq_pkg, stq_ram and stq_cmp.
//
// Usage. Commands arrive as one word on the cmd channel (valid/ready) and
// results leave as words on the res channel (valid/ready). Every command
// gives exactly one result word, except a check that finds expired timers,
// which gives one word per expired timer; the final word of a command has
// last set. The block takes one command at a time: cmd_ready is high only
// while the sequencer is idle.
//
// Operation. The table lives in two RAM banks. A command walks the active bank
// entry by entry and rewrites the survivors, in order, into the other bank;
// the banks swap when the command commits, so a rejected add simply leaves
// the active bank untouched. Each entry passes through S_READ for the
// registered RAM read and S_PROC for the shared compare. A clear or an
// add with a null owner skips the walk and goes straight to S_FINISH. The
// sequencer is idle again in the cycle the final word is offered, so a new
// command can be taken while that word still waits for the receiver.
//
// Reset clears the entry count, the bank select and all handshake state; the
// RAM contents need no clearing because only entries below the count are read.
// When the receiver stalls, the result register holds its word and the
// sequencer waits at the next point where it must emit a word.
module sorted_timer_queue_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  stq_pkg::cmd_word_t cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output stq_pkg::res_word_t res
);
  import stq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_PROC   = 3'd2;
  localparam logic [2:0] S_TAIL   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]            state;
  logic                  bank;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      ridx;
  logic [CNT_W-1:0]      wptr;
  logic [1:0]            op;
  logic [TIME_BITS-1:0]  key_time;
  logic [ID_BITS-1:0]    key_id;
  logic [OWNER_BITS-1:0] key_owner;
  logic                  found;
  logic                  inserted;
  logic                  popping;
  logic                  null_owner;
  logic [NPOP_W-1:0]     npop;
  entry_t                pend;
  logic                  pend_valid;

  entry_t                rdata0;
  entry_t                rdata1;
  entry_t                rd_entry;
  entry_t                new_entry;
  cmp_res_t              cmpr;
  logic                  ram_we;
  entry_t                ram_wdata;
  logic                  wr_ok;
  logic                  out_free;
  logic                  ins_now;
  logic                  pop_now;
  logic [TIME_BITS:0]    sum;
  logic [TIME_BITS-1:0]  sat_expiry;

  // Saturating expiry for an add, worked out once when the command is taken.
  assign sum        = {1'b0, cmd.now[TIME_BITS-1:0]} + {1'b0, cmd.delay[TIME_BITS-1:0]};
  assign sat_expiry = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

  assign cmd_ready = (state == S_IDLE);
  assign out_free  = !res_valid || res_ready;
  assign rd_entry  = bank ? rdata1 : rdata0;
  assign wr_ok     = (wptr < CNT_W'(TIMER_SLOTS));

  assign new_entry.expiry = key_time;
  assign new_entry.id     = key_id;
  assign new_entry.owner  = key_owner;

  stq_cmp u_cmp (
    .entry    (rd_entry),
    .key_time (key_time),
    .key_id   (key_id),
    .result   (cmpr)
  );

  // The new entry goes in front of the first survivor whose expiry is not
  // earlier than its own, which puts it ahead of entries of equal expiry.
  assign ins_now = (op == CMD_ADD) && !inserted && !cmpr.earlier;
  assign pop_now = popping && cmpr.earlier && (npop < NPOP_W'(RESULT_LIMIT));

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = rd_entry;
    unique case (state)
      S_PROC: begin
        if (op == CMD_CHECK) begin
          ram_we = !pop_now && wr_ok;
        end else if (!cmpr.id_match) begin
          ram_we    = wr_ok;
          ram_wdata = ins_now ? new_entry : rd_entry;
        end
      end
      S_TAIL: begin
        ram_we    = !inserted && wr_ok;
        ram_wdata = new_entry;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // The active bank is read; the other bank receives the rewritten table.
  stq_ram #(.WIDTH($bits(entry_t)), .DEPTH(TIMER_SLOTS)) u_bank0 (
    .clk   (clk),
    .we    (ram_we && bank),
    .waddr (wptr[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (ridx[IDX_W-1:0]),
    .rdata (rdata0)
  );

  stq_ram #(.WIDTH($bits(entry_t)), .DEPTH(TIMER_SLOTS)) u_bank1 (
    .clk   (clk),
    .we    (ram_we && !bank),
    .waddr (wptr[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (ridx[IDX_W-1:0]),
    .rdata (rdata1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bank       <= 1'b0;
      count      <= '0;
      res_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op         <= cmd.command;
            key_time   <= (cmd.command == CMD_ADD) ? sat_expiry : cmd.now[TIME_BITS-1:0];
            key_id     <= cmd.timer_id[ID_BITS-1:0];
            key_owner  <= cmd.owner_block;
            ridx       <= '0;
            wptr       <= '0;
            found      <= 1'b0;
            inserted   <= 1'b0;
            popping    <= 1'b1;
            npop       <= '0;
            pend_valid <= 1'b0;
            null_owner <= (cmd.command == CMD_ADD) && (cmd.owner_block == '0);
            if (cmd.command == CMD_CLEAR ||
                (cmd.command == CMD_ADD && cmd.owner_block == '0)) begin
              state <= S_FINISH;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (ridx == count) begin
            state <= (op == CMD_ADD) ? S_TAIL : S_FINISH;
          end else begin
            state <= S_PROC;
          end
        end
        S_PROC: begin
          if (op == CMD_CHECK) begin
            if (pop_now) begin
              // An expired entry is held back one step so that the word
              // before it can be sent knowing it is not the final one.
              if (!pend_valid || out_free) begin
                if (pend_valid) begin
                  res_valid           <= 1'b1;
                  res.status          <= ST_OK;
                  res.expired_valid   <= 1'b1;
                  res.timer_id_res    <= pend.id;
                  res.owner_block_res <= pend.owner;
                  res.expiry_time     <= pend.expiry;
                  res.last            <= 1'b0;
                end
                pend       <= rd_entry;
                pend_valid <= 1'b1;
                npop       <= npop + NPOP_W'(1);
                ridx       <= ridx + CNT_W'(1);
                state      <= S_READ;
              end
            end else begin
              popping <= 1'b0;
              wptr    <= wptr + CNT_W'(1);
              ridx    <= ridx + CNT_W'(1);
              state   <= S_READ;
            end
          end else if (cmpr.id_match) begin
            found <= 1'b1;
            ridx  <= ridx + CNT_W'(1);
            state <= S_READ;
          end else if (ins_now) begin
            // The current entry is still on the read port; it is copied next cycle.
            inserted <= 1'b1;
            wptr     <= wptr + CNT_W'(1);
          end else begin
            wptr  <= wptr + CNT_W'(1);
            ridx  <= ridx + CNT_W'(1);
            state <= S_READ;
          end
        end
        S_TAIL: begin
          if (!inserted) begin
            wptr <= wptr + CNT_W'(1);
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            res_valid           <= 1'b1;
            res.status          <= ST_OK;
            res.expired_valid   <= 1'b0;
            res.timer_id_res    <= '0;
            res.owner_block_res <= '0;
            res.expiry_time     <= '0;
            res.last            <= 1'b1;
            state               <= S_IDLE;
            unique case (op)
              CMD_ADD: begin
                if (null_owner) begin
                  res.status <= ST_NULL_OWNER;
                end else if (count == CNT_W'(TIMER_SLOTS) && !found) begin
                  res.status <= ST_FULL;
                end else begin
                  bank  <= !bank;
                  count <= wptr;
                end
              end
              CMD_DELETE: begin
                bank  <= !bank;
                count <= wptr;
              end
              CMD_CHECK: begin
                if (pend_valid) begin
                  res.expired_valid   <= 1'b1;
                  res.timer_id_res    <= pend.id;
                  res.owner_block_res <= pend.owner;
                  res.expiry_time     <= pend.expiry;
                end
                pend_valid <= 1'b0;
                bank       <= !bank;
                count      <= wptr;
              end
              CMD_CLEAR: begin
                count <= '0;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
